[rtl/sis_pkg.sv]
package sis_pkg;

  localparam int DEF_CAPACITY = 64;
  localparam int VALUE_W      = 32;
  localparam int COUNT_W      = 7;

  localparam logic [1:0] ACT_TEST   = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;

  typedef logic signed [VALUE_W-1:0] value_t;

  typedef struct packed {
    logic [1:0] action;
    value_t     value;
  } req_t;

  typedef struct packed {
    logic               was_member;
    logic [COUNT_W-1:0] member_count;
    logic               overflow;
  } rsp_t;

  // what one cell shows its neighbours
  typedef struct packed {
    value_t data;
    logic   valid;
    logic   after;   // slot holds a value >= key, or is empty
  } link_t;

  // broadcast to every cell
  typedef struct packed {
    value_t key;
    logic   ins;
    logic   rem;
  } cell_ctl_t;

endpackage

[rtl/sis_cell.sv]
module sis_cell
  import sis_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  input  link_t     left,
  input  link_t     right,
  output link_t     self,
  output logic      eq
);

  value_t data;
  logic   valid;
  value_t data_next;
  logic   valid_next;
  logic   ge;

  assign ge = valid && (data >= ctl.key);
  assign eq = valid && (data == ctl.key);

  assign self.data  = data;
  assign self.valid = valid;
  assign self.after = ge || !valid;

  always_comb begin
    data_next  = data;
    valid_next = valid;
    if (ctl.ins && self.after) begin
      if (left.after) begin
        data_next  = left.data;
        valid_next = left.valid;
      end else begin
        data_next  = ctl.key;
        valid_next = 1'b1;
      end
    end else if (ctl.rem && ge) begin
      data_next  = right.data;
      valid_next = right.valid;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

endmodule

[rtl/sorted_integer_set_top.sv]
// Sorted set of distinct signed 32-bit integers, up to CAPACITY members.
// Request channel: req (action, value) is taken at a clock edge with start
// high and busy low. Actions: test membership, insert, remove; code 3 tests.
// Result channel: rsp (was_member, member_count, overflow) is shown for one
// cycle with done high, once the request has passed the input register
// (cur, pending) and then the result register. There is no back-pressure:
// the receiver must take every result as it comes.
// Throughput: one request per cycle while busy is low. Each request is held
// in an input register, then all cells compare the key in parallel and shift
// in that same cycle; a request taken meanwhile sees the updated set.
// member_count carries the low seven bits of the count.
// Reset (rst, synchronous) empties the set; busy is high during reset and
// for the cycle after it.
module sorted_integer_set_top
  import sis_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
)(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic done,
  output rsp_t rsp
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic             pending;
  req_t             cur;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  link_t                links [CAPACITY];
  logic  [CAPACITY-1:0] eq_vec;
  logic  [CAPACITY-1:0] valid_vec;
  link_t                left_end;
  link_t                right_end;
  cell_ctl_t            ctl;

  logic present;
  logic full;
  logic is_ins;
  logic is_rem;
  logic ovf;

  assign present = |eq_vec;
  assign full    = valid_vec[CAPACITY-1];
  assign is_ins  = pending && (cur.action == ACT_INSERT) && !present;
  assign is_rem  = pending && (cur.action == ACT_REMOVE) && present;
  assign ovf     = is_ins && full;

  assign ctl.key = cur.value;
  assign ctl.ins = is_ins && !full;
  assign ctl.rem = is_rem;

  assign left_end.data   = cur.value;
  assign left_end.valid  = 1'b1;
  assign left_end.after  = 1'b0;
  assign right_end.data  = cur.value;
  assign right_end.valid = 1'b0;
  assign right_end.after = 1'b1;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    sis_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctl   (ctl),
      .left  ((i == 0) ? left_end : links[(i == 0) ? 0 : i - 1]),
      .right ((i == CAPACITY - 1) ? right_end
                                  : links[(i == CAPACITY - 1) ? i : i + 1]),
      .self  (links[i]),
      .eq    (eq_vec[i])
    );
    assign valid_vec[i] = links[i].valid;
  end

  always_comb begin
    count_next = count;
    if (ctl.ins) begin
      count_next = count + CNT_W'(1);
    end else if (ctl.rem) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cur <= req;
    end
    rsp.was_member   <= present;
    rsp.member_count <= COUNT_W'(count_next);
    rsp.overflow     <= ovf;
    if (rst) begin
      busy    <= 1'b1;
      pending <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      busy    <= 1'b0;
      pending <= start && !busy;
      done    <= pending;
      count   <= count_next;
    end
  end

  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == count)
    else $error("member count differs from occupied cells");

  a_packed_low: assert property (@(posedge clk) disable iff (rst)
    (valid_vec & (valid_vec + CAPACITY'(1))) == '0)
    else $error("occupied cells not packed from the low end");

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(pending))
    else $error("result without a request in flight");

  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    ovf |-> (count == CNT_W'(CAPACITY)))
    else $error("overflow while store not full");

endmodule
